// ----- rtl/tsp_pkg.sv -----
`timescale 1ns / 1ps
package tsp_pkg;

  // Parser states; each one but ST_INIT also names the class of the character that led to it.
  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_DIGIT = 3'd1;
  localparam logic [2:0] ST_DOT   = 3'd2;
  localparam logic [2:0] ST_COLON = 3'd3;
  localparam logic [2:0] ST_MINUS = 3'd4;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic [1:0] DIGITS_FIELD    = 2'd2;
  localparam logic [1:0] DIGITS_FRACTION = 2'd3;

  localparam logic [21:0] MS_PER_HOUR   = 22'd3600000;
  localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
  localparam logic [9:0]  MS_PER_SECOND = 10'd1000;

  typedef struct packed {
    logic       failed;
    logic       negative;
    logic [9:0] hour;
    logic [9:0] minute;
    logic [9:0] second;
    logic [9:0] milli;
  } parse_rec_t;

  typedef struct packed {
    logic [32:0] total;
    logic        failed;
    logic [9:0]  hour;
    logic [9:0]  minute;
    logic [9:0]  second;
    logic [9:0]  milli;
  } result_t;

endpackage

// ----- rtl/time_string_parser_unit.sv -----
`timescale 1ns / 1ps
// Time string parser: takes a string such as -1:02:03.456 one character per item
// and gives its signed value in milliseconds together with the separate fields.
// Input channel: present an item on char_code, no_char and last with push high;
// it is taken at a clock edge where full is low. no_char marks an item that
// carries no character, so an empty string is a single item with no_char and last.
// Result channel: one result per item with last set; it stands on the result
// ports while empty is low and is taken at an edge where pop is high.
// Throughput is one item per cycle while full is low. Once its last item is taken,
// a result passes on in order: the front parser writes a summary into a short queue,
// the back end forms the scaled fields in one registered stage and sums them into the
// output queue on the next edge. A malformed string gives fallback_ms with
// parse_failed set and all fields zero.
// The fallback register is written by cfg_write with the value on fallback_ms;
// write it only while no string is in flight. Reset clears the parser, both
// queues and the fallback register to zero.
// When the receiver stops popping the output queue fills, the back end stops
// draining the middle queue, and full rises once that queue holds MID_DEPTH items.
module time_string_parser_unit
  import tsp_pkg::*;
#(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_code,
  input  logic               no_char,
  input  logic               last,
  output logic               empty,
  input  logic               pop,
  output logic signed [32:0] total_ms,
  output logic               parse_failed,
  output logic [9:0]         hour_field,
  output logic [9:0]         minute_field,
  output logic [9:0]         second_field,
  output logic [9:0]         milli_field,
  input  logic               cfg_write,
  input  logic signed [32:0] fallback_ms
);

  logic [32:0] fallback;
  logic        take;
  logic        rec_push;
  parse_rec_t  rec_in;
  logic        rec_empty;
  logic        rec_pop;
  logic [$bits(parse_rec_t)-1:0] rec_data;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  result_t     result;

  always_ff @(posedge clk) begin
    if (rst) begin
      fallback <= '0;
    end else if (cfg_write) begin
      fallback <= fallback_ms;
    end
  end

  assign take = push && !full;

  tsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_code (char_code),
    .no_char   (no_char),
    .last      (last),
    .rec_push  (rec_push),
    .rec       (rec_in)
  );

  tsp_fifo #(
    .WIDTH ($bits(parse_rec_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (rec_push),
    .push_data (rec_in),
    .full      (full),
    .pop       (rec_pop),
    .pop_data  (rec_data),
    .empty     (rec_empty),
    .count     (mid_count)
  );

  tsp_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .fallback  (fallback),
    .rec_empty (rec_empty && (mid_count == '0)),
    .rec       (parse_rec_t'(rec_data)),
    .rec_pop   (rec_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  assign total_ms     = signed'(result.total);
  assign parse_failed = result.failed;
  assign hour_field   = result.hour;
  assign minute_field = result.minute;
  assign second_field = result.second;
  assign milli_field  = result.milli;

endmodule

// ----- rtl/tsp_fifo.sv -----
`timescale 1ns / 1ps
module tsp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [WIDTH-1:0]               push_data,
  output logic                           full,
  input  logic                           pop,
  output logic [WIDTH-1:0]               pop_data,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             push_ok;
  logic             pop_ok;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push_ok && !pop_ok) begin
        count <= count + CW'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/tsp_front.sv -----
`timescale 1ns / 1ps
module tsp_front
  import tsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] char_code,
  input  logic       no_char,
  input  logic       last,
  output logic       rec_push,
  output parse_rec_t rec
);

  logic [2:0] state;
  logic [2:0] state_next;
  logic [9:0] slots [4];
  logic [9:0] slots_next [4];
  logic [1:0] digits_left;
  logic [1:0] digits_left_next;
  logic       negative;
  logic       negative_next;
  logic       dot_seen;
  logic       dot_seen_next;
  logic       error_seen;
  logic       error_seen_next;

  logic [2:0] cls;
  logic       cls_ok;
  logic [7:0] allowed;
  logic [13:0] times_ten;

  always_comb begin
    cls    = ST_INIT;
    cls_ok = 1'b1;
    if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
      cls = ST_DIGIT;
    end else if (char_code == CHAR_DOT) begin
      cls = ST_DOT;
    end else if (char_code == CHAR_COLON) begin
      cls = ST_COLON;
    end else if (char_code == CHAR_MINUS) begin
      cls = ST_MINUS;
    end else begin
      cls_ok = 1'b0;
    end
  end

  // Bit n of the mask is set where the class n may follow the current state.
  always_comb begin
    allowed = '0;
    case (state)
      ST_INIT: begin
        allowed[ST_DIGIT] = 1'b1;
        allowed[ST_MINUS] = 1'b1;
      end
      ST_DIGIT: begin
        allowed[ST_DIGIT] = 1'b1;
        allowed[ST_DOT]   = 1'b1;
        allowed[ST_COLON] = 1'b1;
      end
      ST_DOT, ST_COLON, ST_MINUS: begin
        allowed[ST_DIGIT] = 1'b1;
      end
      default: begin
        allowed = '0;
      end
    endcase
  end

  assign times_ten = {slots[0], 3'b000} + {3'b000, slots[0], 1'b0};

  always_comb begin
    state_next       = state;
    slots_next       = slots;
    digits_left_next = digits_left;
    negative_next    = negative;
    dot_seen_next    = dot_seen;
    error_seen_next  = error_seen;
    if (take && !no_char && !error_seen) begin
      if (!cls_ok || !allowed[cls]) begin
        error_seen_next = 1'b1;
      end else begin
        case (cls)
          ST_DIGIT: begin
            if (digits_left == 2'd0) begin
              error_seen_next = 1'b1;
            end else begin
              slots_next[0]    = 10'(times_ten + 14'(char_code - CHAR_ZERO));
              digits_left_next = digits_left - 2'd1;
              state_next       = ST_DIGIT;
            end
          end
          ST_DOT, ST_COLON: begin
            slots_next[3]    = slots[2];
            slots_next[2]    = slots[1];
            slots_next[1]    = slots[0];
            slots_next[0]    = '0;
            digits_left_next = (cls == ST_DOT) ? DIGITS_FRACTION : DIGITS_FIELD;
            if (cls == ST_DOT) begin
              dot_seen_next = 1'b1;
            end
            state_next = cls;
          end
          default: begin
            negative_next = 1'b1;
            state_next    = ST_MINUS;
          end
        endcase
      end
    end
  end

  // The summary of a finished string is taken from the updated state.
  always_comb begin
    rec          = '0;
    rec.failed   = error_seen_next;
    if (!error_seen_next) begin
      rec.negative = negative_next;
      if (dot_seen_next) begin
        rec.hour   = slots_next[3];
        rec.minute = slots_next[2];
        rec.second = slots_next[1];
        rec.milli  = slots_next[0];
      end else begin
        rec.hour   = slots_next[2];
        rec.minute = slots_next[1];
        rec.second = slots_next[0];
      end
    end
  end

  assign rec_push = take && last;

  always_ff @(posedge clk) begin
    if (rst || rec_push) begin
      state       <= ST_INIT;
      slots       <= '{default: '0};
      digits_left <= DIGITS_FIELD;
      negative    <= 1'b0;
      dot_seen    <= 1'b0;
      error_seen  <= 1'b0;
    end else begin
      state       <= state_next;
      slots       <= slots_next;
      digits_left <= digits_left_next;
      negative    <= negative_next;
      dot_seen    <= dot_seen_next;
      error_seen  <= error_seen_next;
    end
  end

endmodule

// ----- rtl/tsp_back.sv -----
`timescale 1ns / 1ps
module tsp_back
  import tsp_pkg::*;
#(
  parameter int OUT_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [32:0] fallback,
  input  logic        rec_empty,
  input  parse_rec_t  rec,
  output logic        rec_pop,
  input  logic        pop,
  output logic        empty,
  output result_t     result
);

  localparam int CW = $clog2(OUT_DEPTH + 1);

  logic              s1_valid;
  parse_rec_t        s1_rec;
  logic [31:0]       s1_ph;
  logic [25:0]       s1_pm;
  logic [19:0]       s1_ps;
  logic [31:0]       mag;
  logic [32:0]       mag33;
  result_t           res;
  logic [CW-1:0]     out_count;
  logic [CW:0]       committed;
  logic              out_full;
  logic [$bits(result_t)-1:0] out_data;

  // An item is only issued when the output queue has a place kept for it.
  assign committed = {1'b0, out_count} + (CW + 1)'(s1_valid);
  assign rec_pop   = !rec_empty && (committed < (CW + 1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= rec_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      s1_rec <= rec;
      s1_ph  <= 32'(rec.hour) * 32'(MS_PER_HOUR);
      s1_pm  <= 26'(rec.minute) * 26'(MS_PER_MINUTE);
      s1_ps  <= 20'(rec.second) * 20'(MS_PER_SECOND);
    end
  end

  assign mag   = s1_ph + 32'(s1_pm) + 32'(s1_ps) + 32'(s1_rec.milli);
  assign mag33 = {1'b0, mag};

  always_comb begin
    res        = '0;
    res.failed = s1_rec.failed;
    if (s1_rec.failed) begin
      res.total = fallback;
    end else begin
      res.total  = s1_rec.negative ? (33'd0 - mag33) : mag33;
      res.hour   = s1_rec.hour;
      res.minute = s1_rec.minute;
      res.second = s1_rec.second;
      res.milli  = s1_rec.milli;
    end
  end

  tsp_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_data (res),
    .full      (out_full),
    .pop       (pop),
    .pop_data  (out_data),
    .empty     (empty),
    .count     (out_count)
  );

  // The credit check keeps the queue from overflowing; full only guards the write.
  assign result = out_full ? result_t'(out_data) : result_t'(out_data);

endmodule
